[hdl/dsa_pkg.sv]
`timescale 1ns / 1ps
package dsa_pkg;

  localparam int ELEV_W  = 28;
  localparam int CELL_W  = ELEV_W + 1;
  localparam int SIZE_W  = 32;
  localparam int COUNT_W = 13;
  localparam int AREA_W  = 56;
  localparam int SQ_W    = 2 * SIZE_W;
  localparam int DZ_W    = ELEV_W + 1;
  localparam int DZSQ_W  = 2 * DZ_W;
  localparam int OP_W    = 67;
  localparam int PROD_W  = 2 * OP_W;
  localparam int RAD_W   = 128;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

  localparam logic [AREA_W-1:0]  AREA_MAX           = '1;
  localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 13'd4096;
  localparam logic [SIZE_W-1:0]  CELL_HEIGHT_RESET  = 32'd256;

  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_CELL_HEIGHT  = 1'b1;

  localparam logic [3:0] CENTRE = 4'd4;

  typedef logic [2:0][CELL_W-1:0] column_t;

  typedef struct packed {
    logic [8:0][CELL_W-1:0] cells;
    logic [SIZE_W-1:0]      cell_width;
    logic [SIZE_W-1:0]      cell_height;
    logic                   end_of_row;
  } job_t;

  typedef enum logic [1:0] {FR_IDLE, FR_LOOKUP, FR_PUSH} front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_W2, BK_H2, BK_DA, BK_DB, BK_DAB, BK_PQ, BK_E2, BK_SQRT, BK_OUT
  } back_state_t;

  typedef enum logic [1:0] {SIDE_W, SIDE_H, SIDE_D} side_t;

  // ring order NW N NE E SE S SW W NW, cell index row*3+col
  function automatic logic [3:0] ring_cell(input logic [3:0] pos);
    logic [3:0] idx;
    case (pos)
      4'd0:    idx = 4'd0;
      4'd1:    idx = 4'd1;
      4'd2:    idx = 4'd2;
      4'd3:    idx = 4'd5;
      4'd4:    idx = 4'd8;
      4'd5:    idx = 4'd7;
      4'd6:    idx = 4'd6;
      4'd7:    idx = 4'd3;
      4'd8:    idx = 4'd0;
      default: idx = CENTRE;
    endcase
    return idx;
  endfunction

  function automatic side_t ring_side(input logic [3:0] pos);
    side_t s;
    case (pos)
      4'd1, 4'd5: s = SIDE_H;
      4'd3, 4'd7: s = SIDE_W;
      default:    s = SIDE_D;
    endcase
    return s;
  endfunction

  function automatic side_t far_side(input logic [2:0] t);
    side_t s;
    case (t)
      3'd0, 3'd1, 3'd4, 3'd5: s = SIDE_W;
      default:                s = SIDE_H;
    endcase
    return s;
  endfunction

endpackage

[hdl/dsa_fifo.sv]
`timescale 1ns / 1ps
module dsa_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dsa_pkg::job_t  push_job,
  input  logic           pop,
  output dsa_pkg::job_t  head,
  output logic           full,
  output logic           empty
);
  import dsa_pkg::*;

  job_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hdl/dsa_front.sv]
`timescale 1ns / 1ps
module dsa_front #(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_frame_start,
  input  logic signed [dsa_pkg::ELEV_W-1:0] in_elevation,
  input  logic                              in_elevation_valid,
  input  logic [dsa_pkg::SIZE_W-1:0]        in_cell_width,
  input  logic [dsa_pkg::COUNT_W-1:0]       column_count,
  input  logic [dsa_pkg::SIZE_W-1:0]        cell_height,
  input  logic                              q_full,
  output logic                              q_push,
  output dsa_pkg::job_t                     q_job
);
  import dsa_pkg::*;

  localparam int AW = $clog2(MAX_COLUMNS);

  logic [CELL_W-1:0] upper_mem  [MAX_COLUMNS];
  logic [CELL_W-1:0] middle_mem [MAX_COLUMNS];

  front_state_t      state_r, state_nxt;
  logic [AW-1:0]     col_pos_r;
  logic [1:0]        rows_r;
  logic [SIZE_W-1:0] centre_w_r;
  logic [SIZE_W-1:0] cur_w_r;
  logic [AW-1:0]     c_r;
  logic [CELL_W-1:0] pix_r;
  logic              last_r;
  logic [CELL_W-1:0] upper_rd_r;
  logic [CELL_W-1:0] middle_rd_r;
  column_t           win_r [2];
  job_t              job_a_r, job_b_r;
  logic              need_a_r, need_b_r;

  logic              acc;
  logic [AW-1:0]     c_in;
  logic [31:0]       cnt32;
  logic [31:0]       count_eff;
  logic              last_in;
  column_t           col;
  logic              push_done;

  function automatic job_t make_job(input column_t l, input column_t m, input column_t r,
                                    input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                    input logic eor);
    job_t j;
    for (int k = 0; k < 3; k++) begin
      j.cells[k*3+0] = l[k];
      j.cells[k*3+1] = m[k];
      j.cells[k*3+2] = r[k];
    end
    j.cell_width  = w;
    j.cell_height = h;
    j.end_of_row  = eor;
    return j;
  endfunction

  assign acc   = in_valid && in_ready;
  assign c_in  = in_frame_start ? '0 : col_pos_r;
  assign cnt32 = 32'(column_count);

  always_comb begin
    if (cnt32 == 32'd0) begin
      count_eff = 32'd1;
    end else if (cnt32 > 32'(MAX_COLUMNS)) begin
      count_eff = 32'(MAX_COLUMNS);
    end else begin
      count_eff = cnt32;
    end
  end

  assign last_in = (32'(c_in) + 32'd1 >= count_eff);

  always_comb begin
    col[0] = upper_rd_r;
    col[1] = middle_rd_r;
    col[2] = pix_r;
  end

  assign q_push    = (state_r == FR_PUSH) && !q_full && (need_a_r || need_b_r);
  assign q_job     = need_a_r ? job_a_r : job_b_r;
  assign push_done = !(need_a_r || need_b_r) || (q_push && !(need_a_r && need_b_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE:   if (acc) state_nxt = FR_LOOKUP;
      FR_LOOKUP: state_nxt = FR_PUSH;
      FR_PUSH:   if (push_done) state_nxt = FR_IDLE;
      default:   state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == FR_IDLE);
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      upper_rd_r  <= upper_mem[c_in];
      middle_rd_r <= middle_mem[c_in];
    end
    if (state_r == FR_LOOKUP) begin
      upper_mem[c_r]  <= middle_rd_r;
      middle_mem[c_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      c_r    <= c_in;
      pix_r  <= {in_elevation_valid, in_elevation};
      last_r <= last_in;
    end
    if (state_r == FR_LOOKUP) begin
      job_a_r <= make_job((c_r >= AW'(2)) ? win_r[0] : win_r[1], win_r[1], col,
                          centre_w_r, cell_height, 1'b0);
      job_b_r <= make_job((c_r != '0) ? win_r[1] : col, col, col,
                          centre_w_r, cell_height, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FR_IDLE;
      col_pos_r  <= '0;
      rows_r     <= '0;
      centre_w_r <= '0;
      cur_w_r    <= '0;
      win_r[0]   <= '0;
      win_r[1]   <= '0;
      need_a_r   <= 1'b0;
      need_b_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        if (in_frame_start) begin
          rows_r <= '0;
        end
        if (c_in == '0) begin
          centre_w_r <= cur_w_r;
          cur_w_r    <= in_cell_width;
        end
      end
      if (state_r == FR_LOOKUP) begin
        need_a_r <= (rows_r == 2'd2) && (c_r != '0);
        need_b_r <= (rows_r == 2'd2) && last_r;
        win_r[0] <= win_r[1];
        win_r[1] <= col;
        if (last_r) begin
          col_pos_r <= '0;
          if (rows_r != 2'd2) begin
            rows_r <= rows_r + 2'd1;
          end
        end else begin
          col_pos_r <= c_r + 1'b1;
        end
      end
      if (q_push) begin
        if (need_a_r) begin
          need_a_r <= 1'b0;
        end else begin
          need_b_r <= 1'b0;
        end
      end
    end
  end

endmodule

[hdl/dsa_mul.sv]
`timescale 1ns / 1ps
module dsa_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dsa_pkg::OP_W-1:0]    op_a,
  input  logic [dsa_pkg::OP_W-1:0]    op_b,
  output logic                        done,
  output logic [dsa_pkg::PROD_W-1:0]  product
);
  import dsa_pkg::*;

  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] a_r;
  logic [OP_W-1:0]   b_r;
  logic              run_r;
  logic              done_r;
  logic              busy_bits;

  assign busy_bits = (b_r != '0);
  assign done      = done_r;
  assign product   = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && !busy_bits && !start;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && !busy_bits) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= PROD_W'(op_a);
      b_r   <= op_b;
    end else if (run_r && busy_bits) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

endmodule

[hdl/dsa_back.sv]
`timescale 1ns / 1ps
module dsa_back #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  dsa_pkg::job_t               q_head,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dsa_pkg::AREA_W-1:0]  out_surface_area,
  output logic                        out_area_valid,
  output logic                        out_end_of_row
);
  import dsa_pkg::*;

  localparam int SH     = 8 + 2 * FRACTION_BITS;
  localparam int ITER_W = $clog2(ROOT_W);

  back_state_t       state_r, state_nxt;
  job_t              job_r;
  logic [2:0]        t_r;
  logic [SQ_W-1:0]   w2_r, h2_r;
  logic [DZSQ_W-1:0] sqa_r, sqb_r, sqab_r;
  logic [PROD_W-1:0] pq_r;
  logic [AREA_W-1:0] sum_r;
  logic              pend_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ITER_W-1:0] iter_r;
  logic              out_valid_r;
  logic [AREA_W-1:0] area_r;
  logic              area_valid_r;
  logic              eor_r;

  logic              mul_state, mul_start, mul_done;
  logic [OP_W-1:0]   op_a, op_b;
  logic [PROD_W-1:0] product;
  logic [ELEV_W-1:0] zc, za, zb;
  logic [CELL_W-1:0] ca, cb;
  logic [DZ_W-1:0]   dza, dzb, dzab;
  logic [SQ_W:0]     d2;
  logic [OP_W-1:0]   p_val, q_val, r_val, e_val;
  logic [OP_W:0]     s_sum, r_ext;
  logic [PROD_W+1:0] f_val, e2_val, d_val;
  logic [RAD_W-1:0]  rad_in;
  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;
  logic [ROOT_W-1:0] root_nxt;
  logic [AREA_W+8:0] tot;
  logic              sqrt_last, out_free;

  function automatic logic [DZ_W-1:0] abs_diff(input logic [ELEV_W-1:0] x,
                                               input logic [ELEV_W-1:0] y);
    logic [DZ_W-1:0] d;
    d = {x[ELEV_W-1], x} - {y[ELEV_W-1], y};
    return d[DZ_W-1] ? (~d + 1'b1) : d;
  endfunction

  function automatic logic [SQ_W:0] side_val(input side_t s, input logic [SQ_W-1:0] w2,
                                             input logic [SQ_W-1:0] h2,
                                             input logic [SQ_W:0] dd);
    logic [SQ_W:0] v;
    case (s)
      SIDE_W:  v = {1'b0, w2};
      SIDE_H:  v = {1'b0, h2};
      default: v = dd;
    endcase
    return v;
  endfunction

  dsa_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (op_a),
    .op_b    (op_b),
    .done    (mul_done),
    .product (product)
  );

  assign zc   = job_r.cells[CENTRE][ELEV_W-1:0];
  assign ca   = job_r.cells[ring_cell({1'b0, t_r})];
  assign cb   = job_r.cells[ring_cell({1'b0, t_r} + 4'd1)];
  assign za   = ca[ELEV_W] ? ca[ELEV_W-1:0] : zc;
  assign zb   = cb[ELEV_W] ? cb[ELEV_W-1:0] : zc;
  assign dza  = abs_diff(za, zc);
  assign dzb  = abs_diff(zb, zc);
  assign dzab = abs_diff(za, zb);
  assign d2   = {1'b0, w2_r} + {1'b0, h2_r};

  assign p_val = OP_W'(side_val(ring_side({1'b0, t_r}), w2_r, h2_r, d2)) + OP_W'(sqa_r);
  assign q_val = OP_W'(side_val(ring_side({1'b0, t_r} + 4'd1), w2_r, h2_r, d2))
               + OP_W'(sqb_r);
  assign r_val = OP_W'(side_val(far_side(t_r), w2_r, h2_r, d2)) + OP_W'(sqab_r);
  assign s_sum = {1'b0, p_val} + {1'b0, q_val};
  assign r_ext = {1'b0, r_val};
  assign e_val = (s_sum >= r_ext) ? OP_W'(s_sum - r_ext) : OP_W'(r_ext - s_sum);

  assign f_val  = {pq_r, 2'b00};
  assign e2_val = {2'b00, product};
  assign d_val  = f_val - e2_val;
  assign rad_in = (f_val > e2_val) ? RAD_W'(d_val >> SH) : '0;

  assign rem_sh    = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial     = REM_W'({root_r, 2'b01});
  assign ge        = (rem_sh >= trial);
  assign root_nxt  = {root_r[ROOT_W-2:0], ge};
  assign tot       = (AREA_W+9)'(sum_r) + (AREA_W+9)'(root_nxt);
  assign sqrt_last = (iter_r == ITER_W'(ROOT_W - 1));
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    case (state_r)
      BK_W2, BK_H2, BK_DA, BK_DB, BK_DAB, BK_PQ, BK_E2: mul_state = 1'b1;
      default: mul_state = 1'b0;
    endcase
  end

  assign mul_start = mul_state && !pend_r;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      BK_W2: begin
        op_a = OP_W'(job_r.cell_width);
        op_b = OP_W'(job_r.cell_width);
      end
      BK_H2: begin
        op_a = OP_W'(job_r.cell_height);
        op_b = OP_W'(job_r.cell_height);
      end
      BK_DA: begin
        op_a = OP_W'(dza);
        op_b = OP_W'(dza);
      end
      BK_DB: begin
        op_a = OP_W'(dzb);
        op_b = OP_W'(dzb);
      end
      BK_DAB: begin
        op_a = OP_W'(dzab);
        op_b = OP_W'(dzab);
      end
      BK_PQ: begin
        op_a = p_val;
        op_b = q_val;
      end
      BK_E2: begin
        op_a = e_val;
        op_b = e_val;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_head.cells[CENTRE][ELEV_W] ? BK_W2 : BK_OUT;
        end
      end
      BK_W2:   if (mul_done) state_nxt = BK_H2;
      BK_H2:   if (mul_done) state_nxt = BK_DA;
      BK_DA:   if (mul_done) state_nxt = BK_DB;
      BK_DB:   if (mul_done) state_nxt = BK_DAB;
      BK_DAB:  if (mul_done) state_nxt = BK_PQ;
      BK_PQ:   if (mul_done) state_nxt = BK_E2;
      BK_E2:   if (mul_done) state_nxt = BK_SQRT;
      BK_SQRT: if (sqrt_last) state_nxt = (t_r == 3'd7) ? BK_OUT : BK_DA;
      BK_OUT:  if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop            = (state_r == BK_IDLE) && !q_empty;
    out_valid        = out_valid_r;
    out_surface_area = area_r;
    out_area_valid   = area_valid_r;
    out_end_of_row   = eor_r;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    if (mul_done) begin
      case (state_r)
        BK_W2:   w2_r   <= SQ_W'(product);
        BK_H2:   h2_r   <= SQ_W'(product);
        BK_DA:   sqa_r  <= DZSQ_W'(product);
        BK_DB:   sqb_r  <= DZSQ_W'(product);
        BK_DAB:  sqab_r <= DZSQ_W'(product);
        BK_PQ:   pq_r   <= product;
        default: ;
      endcase
    end
    if (state_r == BK_E2 && mul_done) begin
      rad_r  <= rad_in;
      rem_r  <= '0;
      root_r <= '0;
      iter_r <= '0;
    end
    if (state_r == BK_SQRT) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= root_nxt;
      iter_r <= iter_r + 1'b1;
    end
    if (state_r == BK_OUT && out_free) begin
      area_r       <= sum_r;
      area_valid_r <= job_r.cells[CENTRE][ELEV_W];
      eor_r        <= job_r.end_of_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_r      <= 1'b0;
      t_r         <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_start) begin
        pend_r <= 1'b1;
      end else if (mul_done) begin
        pend_r <= 1'b0;
      end
      if (q_pop) begin
        t_r   <= '0;
        sum_r <= '0;
      end
      if (state_r == BK_SQRT && sqrt_last) begin
        t_r   <= t_r + 3'd1;
        sum_r <= (tot > (AREA_W+9)'(AREA_MAX)) ? AREA_MAX : AREA_W'(tot);
      end
      if (state_r == BK_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[hdl/dem_surface_area_3x3.sv]
// Flow: an accepted pixel and its line-buffer column are registered, its jobs, if any, are
//   built in FR_LOOKUP and pushed in FR_PUSH, one per push, into the four-entry job queue.
// Pacing: a new pixel is taken only when the front end is idle again, after the jobs of the
//   last pixel are pushed, and pushes wait while the job queue is full; the shared bit-serial
//   multiplier (one operand bit a cycle) and the radix-2 square root set the rate of results.
// Reset: synchronous active-low rst_n clears control state, window and row widths, and
//   loads column_count 4096 and cell_height 256; line buffers are undefined until written.
`timescale 1ns / 1ps
module dem_surface_area_3x3 #(
  parameter int MAX_COLUMNS   = 4096,
  parameter int FRACTION_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_frame_start,
  input  logic signed [dsa_pkg::ELEV_W-1:0] in_elevation,
  input  logic                              in_elevation_valid,
  input  logic [dsa_pkg::SIZE_W-1:0]        in_cell_width,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dsa_pkg::AREA_W-1:0]        out_surface_area,
  output logic                              out_area_valid,
  output logic                              out_end_of_row,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [dsa_pkg::SIZE_W-1:0]        cfg_data
);
  import dsa_pkg::*;

  logic [COUNT_W-1:0] column_count_r;
  logic [SIZE_W-1:0]  cell_height_r;
  logic               q_push, q_pop, q_full, q_empty;
  job_t               q_job, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COLUMN_COUNT_RESET;
      cell_height_r  <= CELL_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLUMN_COUNT: column_count_r <= cfg_data[COUNT_W-1:0];
        REG_CELL_HEIGHT:  cell_height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  dsa_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_frame_start     (in_frame_start),
    .in_elevation       (in_elevation),
    .in_elevation_valid (in_elevation_valid),
    .in_cell_width      (in_cell_width),
    .column_count       (column_count_r),
    .cell_height        (cell_height_r),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_job              (q_job)
  );

  dsa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  dsa_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_head           (q_head),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_surface_area (out_surface_area),
    .out_area_valid   (out_area_valid),
    .out_end_of_row   (out_end_of_row)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue read while empty");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_area_valid) |-> (out_surface_area == '0))
    else $error("missing centre gave a non-zero area");

endmodule

[verif/dem_surface_area_3x3_test.sv]
`timescale 1ns / 1ps
module dem_surface_area_3x3_test;
  import dsa_pkg::*;

  localparam int MAX_COLS = 4096;
  localparam int SETTLE_CYCLES = 2600;
  localparam int HOLD_CYCLES = 20000;

  localparam int MODE_FREE = 0;
  localparam int MODE_SENDER = 1;
  localparam int MODE_RECEIVER = 2;
  localparam int MODE_BOTH = 3;

  typedef logic [191:0] wide_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              area_ok;
    logic              row_end;
  } area_result_t;

  typedef struct packed {
    logic                     frame_start;
    logic signed [ELEV_W-1:0] elev;
    logic                     elev_ok;
    logic [SIZE_W-1:0]        width;
    logic                     known;
    logic [AREA_W-1:0]        area;
    logic                     area_ok;
  } pixel_row_t;

  localparam logic signed [ELEV_W-1:0] E_MAX = 28'sh7FFFFFF;
  localparam logic signed [ELEV_W-1:0] E_MIN = 28'sh8000000;

  localparam pixel_row_t DIRECTED [21] = '{
    '{1'b1, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b1, 56'd256, 1'b1},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b1, 56'd256, 1'b1},
    '{1'b0, 28'sd0, 1'b0, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b0, 32'd256, 1'b1, 56'd256, 1'b1},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b1, 56'd256, 1'b1},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b1, 56'd0, 1'b0},
    '{1'b0, 28'sd0, 1'b1, 32'd256, 1'b0, 56'd0, 1'b0},
    '{1'b0, E_MAX, 1'b1, 32'hFFFFFFFF, 1'b0, 56'd0, 1'b0},
    '{1'b0, E_MIN, 1'b1, 32'hFFFFFFFF, 1'b0, 56'd0, 1'b0},
    '{1'b0, E_MAX, 1'b0, 32'hFFFFFFFF, 1'b0, 56'd0, 1'b0},
    '{1'b0, E_MIN, 1'b1, 32'd0, 1'b0, 56'd0, 1'b0},
    '{1'b0, E_MAX, 1'b1, 32'd0, 1'b0, 56'd0, 1'b0},
    '{1'b0, -28'sd1, 1'b1, 32'd0, 1'b0, 56'd0, 1'b0}
  };

  localparam int ROW_STEP [9] = '{-1, -1, -1, 0, 1, 1, 1, 0, -1};
  localparam int COL_STEP [9] = '{-1, 0, 1, 1, 1, 0, -1, -1, -1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_frame_start = 1'b0;
  logic signed [ELEV_W-1:0] in_elevation = '0;
  logic in_elevation_valid = 1'b0;
  logic [SIZE_W-1:0] in_cell_width = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [AREA_W-1:0] out_surface_area;
  logic out_area_valid;
  logic out_end_of_row;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_COLUMN_COUNT;
  logic [SIZE_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  dem_surface_area_3x3 i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_frame_start     (in_frame_start),
    .in_elevation       (in_elevation),
    .in_elevation_valid (in_elevation_valid),
    .in_cell_width      (in_cell_width),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_surface_area   (out_surface_area),
    .out_area_valid     (out_area_valid),
    .out_end_of_row     (out_end_of_row),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  logic [CELL_W-1:0] upper_line [MAX_COLS];
  logic [CELL_W-1:0] middle_line [MAX_COLS];
  logic [5:0][CELL_W-1:0] recent_cols;
  int unsigned col_pos;
  int unsigned rows_filled;
  logic [SIZE_W-1:0] centre_width;
  logic [SIZE_W-1:0] row_width;
  logic [COUNT_W-1:0] col_count_reg;
  logic [SIZE_W-1:0] cell_height_reg;

  area_result_t pending_areas [$];
  int errors = 0;
  int idle_mode = MODE_FREE;
  bit hold_go = 1'b0;
  int hold_left = 0;

  function automatic logic [63:0] floor_sqrt(input wide_t n);
    logic [63:0] r;
    logic [63:0] c;
    wide_t cw;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cw = wide_t'(c);
      if (cw * cw <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] triangle_area(input wide_t p, input wide_t q, input wide_t r);
    wide_t s;
    wide_t e;
    wide_t f;
    wide_t e2;
    s = p + q;
    e = (s >= r) ? s - r : r - s;
    e2 = e * e;
    f = p * q * 4;
    if (f <= e2) return '0;
    return 64'((f - e2) >> (8 + 2 * 8)) == 64'd0 ? '0 : floor_sqrt((f - e2) >> (8 + 2 * 8));
  endfunction

  function automatic logic signed [63:0] height_of(input logic [CELL_W-1:0] c);
    logic signed [63:0] z;
    z = 64'($signed(c[ELEV_W-1:0]));
    return z;
  endfunction

  function automatic area_result_t window_area(input logic [8:0][CELL_W-1:0] g,
                                               input logic row_end);
    area_result_t res;
    logic [63:0] wq;
    logic [63:0] hq;
    wide_t w2;
    wide_t h2;
    wide_t d2;
    wide_t ra;
    wide_t rb;
    wide_t ro;
    logic signed [63:0] zc;
    logic signed [63:0] za;
    logic signed [63:0] zb;
    logic signed [63:0] dd;
    logic [63:0] m;
    logic [CELL_W-1:0] a;
    logic [CELL_W-1:0] b;
    logic [63:0] tri_val;
    logic [63:0] sum;
    wide_t sqa;
    wide_t sqb;
    wide_t sqo;
    res.row_end = row_end;
    if (!g[4][ELEV_W]) begin
      res.area = '0;
      res.area_ok = 1'b0;
      return res;
    end
    zc = height_of(g[4]);
    wq = 64'(centre_width);
    hq = 64'(cell_height_reg);
    w2 = wide_t'(wq) * wide_t'(wq);
    h2 = wide_t'(hq) * wide_t'(hq);
    d2 = w2 + h2;
    sum = '0;
    for (int t = 0; t < 8; t++) begin
      a = g[(1 + ROW_STEP[t]) * 3 + 1 + COL_STEP[t]];
      b = g[(1 + ROW_STEP[t+1]) * 3 + 1 + COL_STEP[t+1]];
      za = a[ELEV_W] ? height_of(a) : zc;
      zb = b[ELEV_W] ? height_of(b) : zc;
      ra = (COL_STEP[t] == 0) ? h2 : ((ROW_STEP[t] == 0) ? w2 : d2);
      rb = (COL_STEP[t+1] == 0) ? h2 : ((ROW_STEP[t+1] == 0) ? w2 : d2);
      ro = (ROW_STEP[t] == ROW_STEP[t+1]) ? w2 : h2;
      dd = zc - za;
      m = (dd < 0) ? -dd : dd;
      sqa = wide_t'(m) * wide_t'(m);
      dd = zc - zb;
      m = (dd < 0) ? -dd : dd;
      sqb = wide_t'(m) * wide_t'(m);
      dd = za - zb;
      m = (dd < 0) ? -dd : dd;
      sqo = wide_t'(m) * wide_t'(m);
      tri_val = triangle_area(ra + sqa, rb + sqb, ro + sqo);
      if (tri_val > {8'd0, AREA_MAX} - sum) sum = {8'd0, AREA_MAX};
      else sum = sum + tri_val;
    end
    res.area = sum[AREA_W-1:0];
    res.area_ok = 1'b1;
    return res;
  endfunction

  function automatic void reset_prediction();
    for (int i = 0; i < MAX_COLS; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    recent_cols = '0;
    col_pos = 0;
    rows_filled = 0;
    centre_width = '0;
    row_width = '0;
    col_count_reg = COLUMN_COUNT_RESET;
    cell_height_reg = CELL_HEIGHT_RESET;
  endfunction

  function automatic void predict_pixel(input pixel_row_t px);
    int unsigned count;
    int unsigned c;
    logic [2:0][CELL_W-1:0] col;
    logic [2:0][CELL_W-1:0] left;
    logic [8:0][CELL_W-1:0] g;
    logic last;
    area_result_t res;
    count = 32'(col_count_reg);
    if (count < 1) count = 1;
    if (count > MAX_COLS) count = MAX_COLS;
    if (px.frame_start) begin
      col_pos = 0;
      rows_filled = 0;
    end
    c = col_pos;
    if (c == 0) begin
      centre_width = row_width;
      row_width = px.width;
    end
    col[0] = upper_line[c];
    col[1] = middle_line[c];
    col[2] = {px.elev_ok, px.elev};
    upper_line[c] = col[1];
    middle_line[c] = col[2];
    last = (c + 1 >= count);
    if (rows_filled >= 2) begin
      if (c >= 1) begin
        left = (c >= 2) ? recent_cols[2:0] : recent_cols[5:3];
        for (int r = 0; r < 3; r++) begin
          g[r*3] = left[r];
          g[r*3+1] = recent_cols[3+r];
          g[r*3+2] = col[r];
        end
        res = window_area(g, 1'b0);
        if (px.known) begin
          res.area = px.area;
          res.area_ok = px.area_ok;
        end
        pending_areas.push_back(res);
      end
      if (last) begin
        left = (c >= 1) ? recent_cols[5:3] : col;
        for (int r = 0; r < 3; r++) begin
          g[r*3] = left[r];
          g[r*3+1] = col[r];
          g[r*3+2] = col[r];
        end
        res = window_area(g, 1'b1);
        if (px.known) begin
          res.area = px.area;
          res.area_ok = px.area_ok;
        end
        pending_areas.push_back(res);
      end
    end
    recent_cols[2:0] = recent_cols[5:3];
    recent_cols[5:3] = col;
    if (last) begin
      col_pos = 0;
      if (rows_filled < 2) rows_filled++;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic send_pixel(input pixel_row_t px);
    int gap_pct;
    gap_pct = (idle_mode == MODE_SENDER) ? 62 : ((idle_mode == MODE_BOTH) ? 33 : 0);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_start <= px.frame_start;
    in_elevation <= px.elev;
    in_elevation_valid <= px.elev_ok;
    in_cell_width <= px.width;
    do @(posedge clk); while (!in_ready);
    predict_pixel(px);
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_COLUMN_COUNT) col_count_reg = data[COUNT_W-1:0];
    else cell_height_reg = data;
  endtask

  task automatic configure(input logic [SIZE_W-1:0] count, input logic [SIZE_W-1:0] height);
    write_reg(REG_COLUMN_COUNT, count);
    write_reg(REG_CELL_HEIGHT, height);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_frames(input int n_items, input int frame_rows);
    int unsigned count;
    int frame_len;
    int in_frame;
    logic [ELEV_W-1:0] base;
    pixel_row_t px;
    count = 32'(col_count_reg);
    if (count < 1) count = 1;
    if (count > MAX_COLS) count = MAX_COLS;
    frame_len = frame_rows * int'(count);
    in_frame = frame_len;
    base = '0;
    for (int i = 0; i < n_items; i++) begin
      px = '0;
      if (in_frame >= frame_len) begin
        in_frame = 0;
        base = ELEV_W'($urandom);
        px.frame_start = 1'b1;
      end else begin
        px.frame_start = ($urandom_range(63, 0) == 0);
        if (px.frame_start) in_frame = 0;
      end
      case ($urandom_range(9, 0))
        0, 1:    px.elev = ELEV_W'($urandom);
        2:       px.elev = $urandom_range(1, 0) ? E_MAX : E_MIN;
        default: px.elev = ELEV_W'(32'(base) + $urandom_range(2047, 0) - 32'd1024);
      endcase
      px.elev_ok = ($urandom_range(99, 0) >= 8);
      case ($urandom_range(3, 0))
        0, 1:    px.width = 32'd256;
        2:       px.width = $urandom_range(4096, 1);
        default: px.width = $urandom;
      endcase
      send_pixel(px);
      in_frame++;
    end
    drain();
  endtask

  always @(posedge clk) begin
    area_result_t exp_res;
    int stall_pct;
    if (out_valid && out_ready) begin
      if (pending_areas.size() == 0) begin
        $error("unexpected transfer: area %0d", out_surface_area);
        errors++;
      end else begin
        exp_res = pending_areas.pop_front();
        if (out_surface_area !== exp_res.area) begin
          $error("surface_area: expected %0d, got %0d", exp_res.area, out_surface_area);
          errors++;
        end
        if (out_area_valid !== exp_res.area_ok) begin
          $error("area_valid: expected %0b, got %0b", exp_res.area_ok, out_area_valid);
          errors++;
        end
        if (out_end_of_row !== exp_res.row_end) begin
          $error("end_of_row: expected %0b, got %0b", exp_res.row_end, out_end_of_row);
          errors++;
        end
      end
    end
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    stall_pct = (idle_mode == MODE_RECEIVER) ? 62 : ((idle_mode == MODE_BOTH) ? 33 : 0);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  initial begin
    reset_prediction();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(32'd3, 32'd256);
    for (int i = 0; i < 21; i++) send_pixel(DIRECTED[i]);
    drain();

    configure(32'd0, 32'd0);
    random_frames(60, 8);

    idle_mode = MODE_SENDER;
    configure(32'd3, 32'd256);
    random_frames(300, 5);

    idle_mode = MODE_FREE;
    configure(32'h1FFF, 32'hFFFFFFFF);
    random_frames(120, 3);

    idle_mode = MODE_RECEIVER;
    configure(32'd5, $urandom);
    hold_go = 1'b1;
    random_frames(300, 4);

    idle_mode = MODE_BOTH;
    configure(32'd4, 32'd384);
    random_frames(300, 6);

    idle_mode = MODE_FREE;
    configure(32'd7, $urandom_range(65535, 1));
    random_frames(300, 4);

    idle_mode = MODE_SENDER;
    configure(32'd3, 32'd1);
    random_frames(300, 5);

    idle_mode = MODE_RECEIVER;
    configure(32'd6, $urandom);
    random_frames(160, 4);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd400_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
hdl/dsa_pkg.sv
hdl/dsa_fifo.sv
hdl/dsa_front.sv
hdl/dsa_mul.sv
hdl/dsa_back.sv
hdl/dem_surface_area_3x3.sv
verif/dem_surface_area_3x3_test.sv
